@@ sv/swhc_pkg.sv @@
// Shared types and constants for the sliding-window hit counter.
`timescale 1ns / 1ps
`default_nettype none
package swhc_pkg;

	localparam int TS_W       = 31;
	localparam int COUNT_W    = 16;
	localparam int TOTAL_W    = 25;
	localparam int WINDOW_DEF = 300;
	localparam int DIV_CNT_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(2);

	localparam logic OP_HIT   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic clr_wr;
		logic addr_inc;
		logic rd_slot;
		logic wr_hit;
		logic scan_rd;
		logic out_load;
	} swhc_cmd_t;

	typedef struct packed {
		logic div_last;
		logic addr_last;
		logic out_full;
	} swhc_sts_t;

endpackage
`default_nettype wire

@@ sv/swhc_ctrl.sv @@
// Controller state machine for the sliding-window hit counter.
`timescale 1ns / 1ps
`default_nettype none
module swhc_ctrl
	import swhc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic      s_tuser,
	output logic           s_tready,
	input  wire swhc_sts_t sts,
	output swhc_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_HIT_RD,
		ST_HIT_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.div_step = (state_q == ST_DIV);
		cmd.rd_slot  = (state_q == ST_HIT_RD);
		cmd.wr_hit   = (state_q == ST_HIT_WR);
		cmd.out_load = (state_q == ST_DONE) && !sts.out_full;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr   = 1'b1;
				cmd.addr_inc = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.addr_inc = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.addr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) state_q <= (s_tuser == OP_QUERY) ? ST_SCAN : ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_HIT_RD;
				end
				ST_HIT_RD:   state_q <= ST_HIT_WR;
				ST_HIT_WR:   state_q <= ST_IDLE;
				ST_SCAN: begin
					if (sts.addr_last) state_q <= ST_SCAN_END;
				end
				ST_SCAN_END: state_q <= ST_DONE;
				ST_DONE: begin
					if (!sts.out_full) state_q <= ST_IDLE;
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/swhc_datapath.sv @@
// Bucket memory, slot reduction, window accumulator and output register.
`timescale 1ns / 1ps
`default_nettype none
module swhc_datapath
	import swhc_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire swhc_cmd_t       cmd,
	output swhc_sts_t            sts,
	input  wire logic [TS_W-1:0] ts_in,
	output logic [TOTAL_W-1:0]   total,
	output logic                 total_valid,
	input  wire logic            total_ready
);

	localparam int AW    = $clog2(WINDOW);
	localparam int ENT_W = TS_W + COUNT_W;
	localparam logic [TS_W-1:0] RECIP = TS_W'((64'd1 << TS_W) / WINDOW);

	logic [ENT_W-1:0]     mem_q [WINDOW];
	logic [ENT_W-1:0]     rd_data_q;
	logic [TS_W-1:0]      ts_q;
	logic [TS_W-1:0]      quo_q;
	logic [AW:0]          red_q;
	logic [AW-1:0]        rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [AW-1:0]        addr_q;
	logic                 scan_vld_s1;
	logic [TOTAL_W-1:0]   acc_q;
	logic [TOTAL_W-1:0]   out_total_q;
	logic                 out_valid_q;

	logic [2*TS_W-1:0]    prod;
	logic [AW:0]          red;
	logic [TS_W-1:0]      rd_stamp;
	logic [COUNT_W-1:0]   rd_cnt;
	logic [COUNT_W-1:0]   wr_cnt;
	logic [TS_W:0]        diff;
	logic                 in_win;
	logic [TOTAL_W:0]     sum;
	logic [AW-1:0]        rd_addr;

	assign prod     = (2 * TS_W)'(ts_q) * (2 * TS_W)'(RECIP);
	assign red      = ts_q[AW:0] - quo_q[AW:0] * (AW + 1)'(WINDOW);
	assign rd_stamp = rd_data_q[ENT_W-1:COUNT_W];
	assign rd_cnt   = rd_data_q[COUNT_W-1:0];
	assign wr_cnt   = (rd_stamp != ts_q) ? COUNT_W'(1) :
		(rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
	assign diff     = {1'b0, ts_q} - {1'b0, rd_stamp};
	assign in_win   = $signed(diff) < $signed((TS_W + 1)'(WINDOW));
	assign sum      = {1'b0, acc_q} + (TOTAL_W + 1)'(rd_cnt);
	assign rd_addr  = cmd.rd_slot ? rem_q : addr_q;

	assign sts.div_last  = (div_cnt_q == '0);
	assign sts.addr_last = (addr_q == AW'(WINDOW - 1));
	assign sts.out_full  = out_valid_q;

	assign total       = out_total_q;
	assign total_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem_q[addr_q] <= '0;
		end else if (cmd.wr_hit) begin
			mem_q[rem_q] <= {ts_q, wr_cnt};
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ts_q <= ts_in;
		end else if (cmd.div_step) begin
			quo_q <= prod[2*TS_W-1:TS_W];
			red_q <= red;
		end
		if (cmd.out_load) out_total_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			div_cnt_q   <= '0;
			addr_q      <= '0;
			scan_vld_s1 <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				rem_q     <= '0;
				div_cnt_q <= DIV_LAST_STEP;
				addr_q    <= '0;
				acc_q     <= '0;
			end else begin
				if (cmd.div_step) begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (sts.div_last) begin
						rem_q <= (red_q >= (AW + 1)'(WINDOW)) ?
							AW'(red_q - (AW + 1)'(WINDOW)) : red_q[AW-1:0];
					end
				end
				if (cmd.addr_inc) begin
					addr_q <= sts.addr_last ? '0 : addr_q + AW'(1);
				end
				if (scan_vld_s1 && in_win) begin
					acc_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (total_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < AW'(WINDOW - 1) || rem_q == AW'(WINDOW - 1))
		else $error("slot remainder out of range");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.wr_hit, cmd.rd_slot, cmd.scan_rd}))
		else $error("conflicting memory commands");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q)
		else $error("result loaded over a pending transfer");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_hit |-> wr_cnt != '0)
		else $error("hit write with zero count");

endmodule
`default_nettype wire

@@ sv/sliding_window_hit_counter.sv @@
// Top level of the sliding-window hit counter.
//
//  channel  dir  tdata                     tuser
//  s_*      in   [30:0] timestamp          [0] op (0 hit, 1 query)
//  m_*      out  [24:0] hit_total          -
//
//  After reset a clearing pass writes every bucket with s_tready low.
//  A hit runs through transfer, 3 steps of the reciprocal slot reduction
//  (multiply, fold, final subtract), bucket read, bucket write.
//  A query runs through transfer, one bucket per cycle through the single memory
//  read port, the wait for the last read and the result load.
//  A result waits in the output register; a stalled m_tready holds the next query
//  before its result load.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_hit_counter
	import swhc_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [30:0] timestamp, [31] zero
	input  wire logic        s_tuser,  // [0] op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // [24:0] hit_total, [31:25] zero
);

	swhc_cmd_t          cmd;
	swhc_sts_t          sts;
	logic [TOTAL_W-1:0] total;

	assign m_tdata = {(32 - TOTAL_W)'(0), total};

	swhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swhc_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.ts_in       (s_tdata[TS_W-1:0]),
		.total       (total),
		.total_valid (m_tvalid),
		.total_ready (m_tready)
	);

endmodule
`default_nettype wire

@@ test/swhc_checker.sv @@
// Checker for the sliding-window hit counter: bucket predictor and result compare.
`timescale 1ns / 1ps
module swhc_checker
	import swhc_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // [30:0] timestamp, [31] zero
	input  logic        s_tuser,  // [0] op
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [24:0] hit_total, [31:25] zero
	output int          fail_cnt,
	output int          pending
);

	logic [TS_W-1:0]    stamp_mem [WINDOW];
	logic [COUNT_W-1:0] count_mem [WINDOW];
	logic [TOTAL_W-1:0] due_totals [$];

	function automatic logic [TOTAL_W-1:0] window_total(input logic [TS_W-1:0] ts);
		longint acc;
		longint age;
		acc = 0;
		for (int i = 0; i < WINDOW; i++) begin
			age = longint'(ts) - longint'(stamp_mem[i]);
			if (age < WINDOW) begin
				acc += count_mem[i];
				if (acc > TOTAL_MAX)
					acc = TOTAL_MAX;
			end
		end
		return acc[TOTAL_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [TOTAL_W-1:0] want;
		logic [TS_W-1:0]    ts;
		int unsigned        slot;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				stamp_mem[i] = '0;
				count_mem[i] = '0;
			end
			due_totals.delete();
			fail_cnt = 0;
			pending  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_totals.size() == 0) begin
					report_mismatch("unexpected hit_total transfer", '0, m_tdata);
				end else begin
					want = due_totals.pop_front();
					if (m_tdata !== {{(32 - TOTAL_W){1'b0}}, want})
						report_mismatch("hit_total mismatch", 32'(want), m_tdata);
				end
			end
			if (s_tvalid && s_tready) begin
				ts = s_tdata[TS_W-1:0];
				if (s_tuser == OP_QUERY) begin
					due_totals.insert(due_totals.size(), window_total(ts));
				end else begin
					slot = ts % WINDOW;
					if (stamp_mem[slot] != ts) begin
						stamp_mem[slot] = ts;
						count_mem[slot] = COUNT_W'(1);
					end else if (count_mem[slot] != COUNT_MAX) begin
						count_mem[slot] = count_mem[slot] + COUNT_W'(1);
					end
				end
			end
			pending = due_totals.size();
		end
	end

endmodule

@@ test/tb_sliding_window_hit_counter.sv @@
// Testbench top for the sliding-window hit counter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_sliding_window_hit_counter;
	import swhc_pkg::*;

	localparam longint TS_TOP      = 64'h7FFF_FFFF;
	localparam int     HOLD_CYCLES = 1500;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // [30:0] timestamp, [31] zero
	logic        s_tuser  = 1'b0;  // [0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // [24:0] hit_total, [31:25] zero

	logic   stall_go     = 1'b0;
	int     stall_left   = 0;
	int     rcv_idle_pct = 0;
	int     snd_idle_pct = 0;
	longint wall_sec     = 0;
	int     fail_cnt;
	int     pending;

	sliding_window_hit_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	swhc_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_cnt(fail_cnt),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_go) begin
			m_tready   <= 1'b0;
			stall_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_item(input logic op, input logic [TS_W-1:0] ts);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, ts};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic run_random(input int n);
		longint ts;
		int     pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				ts = $urandom_range(32'h7FFF_FFFF, 0);
			end else begin
				pick = $urandom_range(99);
				if (pick >= 97)
					wall_sec = $urandom_range(32'h7FFF_FFFF, 0);
				else if (pick >= 90)
					wall_sec += $urandom_range(900, 300);
				else if (pick >= 70)
					wall_sec += $urandom_range(299, 1);
				else if (pick >= 40)
					wall_sec += $urandom_range(5, 1);
				if (wall_sec > TS_TOP)
					wall_sec = $urandom_range(1000, 0);
				ts = wall_sec;
			end
			send_item(($urandom_range(99) < 40) ? OP_QUERY : OP_HIT, ts[TS_W-1:0]);
		end
	endtask

	initial begin
		snd_idle_pct = 32;
		rcv_idle_pct <= 69;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_HIT, 0);
		send_item(OP_HIT, 0);
		send_item(OP_QUERY, 0);
		send_item(OP_QUERY, 299);
		send_item(OP_QUERY, 300);
		send_item(OP_HIT, 299);
		send_item(OP_HIT, 299);
		send_item(OP_HIT, 300);
		send_item(OP_QUERY, 300);
		send_item(OP_QUERY, 598);
		send_item(OP_QUERY, 599);
		send_item(OP_HIT, 31'h7FFF_FFFF);
		send_item(OP_HIT, 31'h7FFF_FFFF);
		send_item(OP_QUERY, 31'h7FFF_FFFF);
		send_item(OP_QUERY, 5);
		send_item(OP_HIT, 31'h7FFF_FFFE);
		send_item(OP_HIT, 31'h5555_5555);
		send_item(OP_HIT, 31'h2AAA_AAAA);
		send_item(OP_QUERY, 31'h2AAA_AAB4);
		send_item(OP_QUERY, 0);
		drain_results;

		run_random(160);
		drain_results;

		snd_idle_pct = 69;
		rcv_idle_pct <= 32;
		run_random(160);
		drain_results;

		snd_idle_pct = 0;
		rcv_idle_pct <= 0;
		stall_go <= 1'b1;
		@(posedge clk);
		stall_go <= 1'b0;
		for (int k = 0; k < 6; k++)
			send_item(OP_QUERY, wall_sec[TS_W-1:0]);
		drain_results;

		run_random(160);
		drain_results;
		repeat (WINDOW_DEF + 40) @(posedge clk);

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
sv/swhc_pkg.sv
sv/swhc_ctrl.sv
sv/swhc_datapath.sv
sv/sliding_window_hit_counter.sv
test/swhc_checker.sv
test/tb_sliding_window_hit_counter.sv
